### src/sidta_pkg.sv
// ----------------------------------------------------------------------------
// sidta_pkg: shared definitions for the signed integer to ASCII unit
// Widths, character codes, the queue item and the back-end state type.
// ----------------------------------------------------------------------------
package sidta_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int INPUT_WIDTH   = 32;
  localparam int IN_TDATA_W    = ((INPUT_WIDTH + 7) / 8) * 8;
  localparam int CHAR_WIDTH    = 6;
  localparam int OUT_TDATA_W   = ((CHAR_WIDTH + 7) / 8) * 8;

  // Decimal digits needed for a magnitude of up to 2^(VALUE_WIDTH-1).
  localparam int DIGITS        = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_WIDTH     = DIGITS * 4;
  localparam int REM_W         = $clog2(DIGITS + 1);

  // The binary to BCD converter takes two magnitude bits per cycle.
  localparam int BITS_PER_STEP = 2;
  localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHIFT_WIDTH   = STEPS * BITS_PER_STEP;
  localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = CHAR_WIDTH'(48);
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(45);

  typedef struct packed {
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;
  } sidta_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONVERT,
    BK_SIGN,
    BK_EMIT
  } back_state_t;

endpackage

### src/sidta_front.sv
// ----------------------------------------------------------------------------
// sidta_front: input stage
// Accepts a value, splits it into sign and unsigned magnitude and holds the
// result in a register until the queue takes it.
// ----------------------------------------------------------------------------
module sidta_front import sidta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sidta_item_t           out_item
);

  logic [IN_TDATA_W+VALUE_WIDTH-1:0] extended;
  logic [VALUE_WIDTH-1:0]            raw;
  logic                              accept;
  sidta_item_t                       classified;

  always_comb begin
    extended            = {{VALUE_WIDTH{1'b0}}, s_tdata};
    raw                 = extended[VALUE_WIDTH-1:0];
    classified.negative = raw[VALUE_WIDTH-1];
    // Unsigned negation, so the most negative value gives 2^(VALUE_WIDTH-1).
    classified.magnitude = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
  end

  assign s_tready = !out_valid || out_ready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= classified;
    end
  end

endmodule

### src/sidta_queue.sv
// ----------------------------------------------------------------------------
// sidta_queue: short request queue
// Holds classified requests between the input stage and the converter.
// ----------------------------------------------------------------------------
module sidta_queue import sidta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sidta_item_t in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output sidta_item_t out_item
);

  sidta_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != QCNT_W'(0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

### src/sidta_back.sv
// ----------------------------------------------------------------------------
// sidta_back: converter and character emitter
// Turns a magnitude into BCD by shift-and-add-3, two bits per cycle, then
// sends the sign and the digits, most significant first, without leading
// zeros.
// ----------------------------------------------------------------------------
module sidta_back import sidta_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  sidta_item_t            q_item,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  back_state_t              state;
  back_state_t              state_next;
  logic [SHIFT_WIDTH-1:0]   shreg;
  logic [BCD_WIDTH-1:0]     bcd;
  logic [STEP_W-1:0]        step;
  logic [REM_W-1:0]         remaining;
  logic                     negative;
  logic                     started;
  logic [3:0]               top_digit;
  logic                     show;
  logic                     last_digit;
  logic [CHAR_WIDTH-1:0]    character;

  function automatic logic [BCD_WIDTH-1:0] dabble(input logic [BCD_WIDTH-1:0] value,
                                                  input logic            in_bit);
    logic [BCD_WIDTH-1:0] adjusted;
    adjusted = value;
    for (int d = 0; d < DIGITS; d++) begin
      if (adjusted[d*4 +: 4] >= 4'd5) begin
        adjusted[d*4 +: 4] = adjusted[d*4 +: 4] + 4'd3;
      end
    end
    return {adjusted[BCD_WIDTH-2:0], in_bit};
  endfunction

  always_comb begin
    top_digit  = bcd[BCD_WIDTH-1 -: 4];
    last_digit = remaining == REM_W'(1);
    // The final digit is always sent, so zero still prints as '0'.
    show       = started || (top_digit != 4'd0) || last_digit;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) state_next = BK_CONVERT;
      end
      BK_CONVERT: begin
        if (step == STEP_W'(STEPS - 1)) state_next = negative ? BK_SIGN : BK_EMIT;
      end
      BK_SIGN: begin
        if (m_tready) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (show && m_tready && last_digit) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    m_tvalid  = 1'b0;
    m_tlast   = 1'b0;
    character = ASCII_ZERO + CHAR_WIDTH'(top_digit);
    case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
      end
      BK_SIGN: begin
        m_tvalid  = 1'b1;
        character = ASCII_MINUS;
      end
      BK_EMIT: begin
        m_tvalid = show;
        m_tlast  = last_digit;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
    m_tdata = OUT_TDATA_W'(character);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      step      <= '0;
      remaining <= '0;
      started   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        BK_IDLE: begin
          step      <= '0;
          remaining <= REM_W'(DIGITS);
          started   <= 1'b0;
        end
        BK_CONVERT: begin
          step <= step + STEP_W'(1);
        end
        BK_EMIT: begin
          // A leading zero is dropped without waiting for the sink.
          if (!show || m_tready) begin
            remaining <= remaining - REM_W'(1);
            started   <= started | show;
          end
        end
        default: begin
          step <= step;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          shreg    <= SHIFT_WIDTH'(q_item.magnitude);
          negative <= q_item.negative;
          bcd      <= '0;
        end
      end
      BK_CONVERT: begin
        bcd   <= dabble(dabble(bcd, shreg[SHIFT_WIDTH-1]), shreg[SHIFT_WIDTH-2]);
        shreg <= {shreg[SHIFT_WIDTH-3:0], 2'b00};
      end
      BK_EMIT: begin
        if (!show || m_tready) begin
          bcd <= {bcd[BCD_WIDTH-5:0], 4'd0};
        end
      end
      default: begin
        bcd <= bcd;
      end
    endcase
  end

endmodule

### src/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed integer to decimal ASCII text
// Each input request carries one two's complement value; the output stream
// carries its decimal characters, most significant first, tlast on the last.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                          Marker
//  s_*       in         tdata[31:0] value (signed)       -
//  m_*       out        tdata[5:0] character, [7:6] 0    tlast = last character
//
// The converter loads a request and runs the shift-and-add-3 loop (two
// magnitude bits a cycle), then scans the ten BCD digits one a cycle, a
// shown digit waiting while the sink stalls; a negative value gets a minus
// sign first. A two-entry queue lets the input stage take new requests
// while the converter works or the sink stalls. Reset clears control state
// only; there is no clearing pass.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit import sidta_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] character, [7:6] zero
  output logic                   m_tlast
);

  logic        front_valid;
  logic        front_ready;
  sidta_item_t front_item;
  logic        q_valid;
  logic        q_ready;
  sidta_item_t q_item;

  sidta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  sidta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  sidta_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // Only a minus sign or a decimal digit ever leaves the unit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[CHAR_WIDTH-1:0] == ASCII_MINUS) ||
                 ((m_tdata[CHAR_WIDTH-1:0] >= ASCII_ZERO) &&
                  (m_tdata[CHAR_WIDTH-1:0] <= ASCII_ZERO + CHAR_WIDTH'(9))))
    else $error("output character outside the decimal set");

  // A minus sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[CHAR_WIDTH-1:0] == ASCII_MINUS) |-> !m_tlast)
    else $error("minus sign flagged as last character");

  // The first digit after a minus sign is never zero.
  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata[CHAR_WIDTH-1:0] == ASCII_MINUS)
    |=> !(m_tvalid && (m_tdata[CHAR_WIDTH-1:0] == ASCII_ZERO)))
    else $error("leading zero sent after minus sign");

  // The input stage never holds a request while the queue has room for it.
  a_front_drains: assert property (@(posedge clk) disable iff (rst)
    front_valid && front_ready |=> !front_valid || $past(s_tvalid && s_tready))
    else $error("input stage kept a request the queue accepted");
`endif

endmodule

### verif/sidta_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sidta_text_checker: scoreboard for the signed integer to ASCII unit
// Watches both stream channels. Each accepted request is turned into the
// decimal characters it should produce, and every accepted output character
// is compared with the oldest of them.
// ----------------------------------------------------------------------------
module sidta_text_checker import sidta_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] character, [7:6] zero
  input  logic                   m_tlast,
  output int                     mismatches,
  output int                     pending
);

  localparam int RADIX = 10;

  typedef struct {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } text_char_t;

  text_char_t expected_text[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Queues the decimal text of one request, most significant character first.
  function automatic void queue_decimal_text(input logic [IN_TDATA_W-1:0] word);
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [CHAR_WIDTH-1:0]  digit_chars[$];
    text_char_t             entry;
    raw = word[VALUE_WIDTH-1:0];
    // Negating in unsigned arithmetic keeps the most negative value exact.
    mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    do begin
      digit_chars.push_front(ASCII_ZERO + CHAR_WIDTH'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (raw[VALUE_WIDTH-1]) begin
      entry.character = ASCII_MINUS;
      entry.last      = 1'b0;
      expected_text.push_back(entry);
    end
    foreach (digit_chars[i]) begin
      entry.character = digit_chars[i];
      entry.last      = (i == digit_chars.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          $error("character %0d arrived with no request outstanding",
                 m_tdata[CHAR_WIDTH-1:0]);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (m_tdata[CHAR_WIDTH-1:0] !== want.character) begin
            $error("character: expected %0d, got %0d", want.character,
                   m_tdata[CHAR_WIDTH-1:0]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        queue_decimal_text(s_tdata);
    end
    pending <= expected_text.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the signed integer to ASCII unit
// Sends directed edge values and then random integers of every digit count,
// with bursty requests and a stalling sink; the checker does the comparing.
// ----------------------------------------------------------------------------
module testbench import sidta_pkg::*; ();

  localparam int RANDOM_REQUESTS = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 60;

  typedef enum int {STALL_NONE, STALL_CHOPPY, STALL_LONG} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  int          mismatches;
  int          pending;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  int          ready_hold = 0;
  stall_mode_t stall_mode = STALL_NONE;

  signed_int_to_decimal_ascii_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sidta_text_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sink readiness follows its own pattern, independent of the sender.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          m_tready = 1'b1;
        end
        STALL_CHOPPY: begin
          m_tready   = $urandom_range(0, 1);
          ready_hold = $urandom_range(0, 3);
        end
        default: begin
          m_tready   = ($urandom_range(0, 3) != 0);
          ready_hold = m_tready ? $urandom_range(0, 12) : $urandom_range(4, 24);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    s_tvalid = 1'b1;
    s_tdata  = value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  // Mostly values of a random digit count, some near powers of ten,
  // and some fully random words.
  function automatic logic [31:0] random_value();
    int unsigned pick;
    int unsigned span;
    logic [31:0] value;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      value = $urandom();
    end else begin
      span = 1;
      repeat ($urandom_range(1, 9)) span = span * 10;
      if (pick < 5)
        value = span - $urandom_range(0, 1);
      else
        value = $urandom_range(0, span - 1);
      if ($urandom_range(0, 1))
        value = -value;
    end
    return value;
  endfunction

  task automatic run_random(input int count, input int gaps, input stall_mode_t mode);
    gap_max    = gaps;
    stall_mode = mode;
    repeat (count) send_request(random_value());
  endtask

  initial begin
    logic [31:0] edge_values[$];
    edge_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                    32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                    32'd1000000000, 32'd999999999, -32'sd999999999, 32'd123456789,
                    -32'sd1000000000, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd1, 32'd7};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gap_max    = 30;
    stall_mode = STALL_CHOPPY;
    foreach (edge_values[i]) send_request(edge_values[i]);

    run_random(RANDOM_REQUESTS / 4, 0, STALL_NONE);
    run_random(RANDOM_REQUESTS / 4, 40, STALL_CHOPPY);
    run_random(RANDOM_REQUESTS / 4, 6, STALL_LONG);
    run_random(RANDOM_REQUESTS / 4, 20, STALL_CHOPPY);
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
